// ===== rtl/mcpwm_pkg.sv =====
// shared constants, request codes and controller/datapath interface structs
// for the multi-channel pwm generator; no dependencies
package mcpwm_pkg;

   localparam int CHANNELS_DEFAULT   = 16;
   localparam int RESOLUTION_DEFAULT = 4096;

   localparam int PERIOD_W    = 20;
   localparam int FUNC_W      = 3;
   localparam int CHAN_W      = 8;
   localparam int COUNT_W     = 12;
   localparam int PULSE_W     = 16;
   localparam int LEVELS_W    = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd20000;

   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP  = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK       = 3'd0,
      FUNC_SET_COUNTS = 3'd1,
      FUNC_SET_PULSE  = 3'd2,
      FUNC_READ       = 3'd3,
      FUNC_DETACH     = 3'd4
   } func_type;

   typedef struct packed {
      logic req_load;
      logic do_tick;
      logic do_detach;
      logic cnt_write;
      logic pls_write;
      logic div_init;
      logic div_step;
      logic addr_sweep;
      logic mul_from_ram;
      logic rd_capture;
      logic sweep_start;
      logic sweep_write;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     ch_valid;
      logic     pulse_full;
      logic     div_last;
      logic     sweep_last;
      logic     sweep_pending;
   } ctrl_sts_type;

endpackage

// ===== rtl/multi_channel_pwm_generator.sv =====
// top level of the multi-channel pwm generator: sequencer, datapath and count ram
// depends on mcpwm_pkg, mcpwm_ctrl, mcpwm_dp and mcpwm_ram
//
// usage
//   request channel (req_valid/req_stall): one request per tick or channel command
//   (tick, set on/off counts, set pulse width, read back, detach). every request
//   gives exactly one response on rsp_valid/rsp_stall with the pin levels after the
//   request, an out-of-range status and the read-back counts.
//   csr port: csr_we with csr_index 0 writes the period in us ticks, 1 the sleep bit.
//   from request accept, tick, detach, unused codes and bad channels go straight to
//   the response; set counts, read and a full-period pulse first pass a write or
//   read-wait state; a shorter set pulse first runs the one-bit-per-cycle divider.
//   one request at a time: a new request is taken only after its response is registered.
//   the response register frees the request side: a request is accepted while the
//   previous response still waits; a finished request waits in its last state while
//   rsp_stall holds the previous response.
//   a period write while awake, or leaving sleep, starts a recompute of the shown
//   channels' high times (up to 16) by read, multiply, write; requests stall meanwhile.
//   reset: period 20000, awake, all channels detached, frame counter at zero.
module multi_channel_pwm_generator
   import mcpwm_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEFAULT,
   parameter int RESOLUTION = RESOLUTION_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [CHAN_W-1:0]      req_channel,
   input  logic [COUNT_W-1:0]     req_on_count,
   input  logic [COUNT_W-1:0]     req_off_count,
   input  logic [PULSE_W-1:0]     req_pulse_us,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LEVELS_W-1:0]    rsp_pin_levels,
   output logic                   rsp_status,
   output logic [COUNT_W-1:0]     rsp_read_on,
   output logic [COUNT_W-1:0]     rsp_read_off,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = $clog2(RESOLUTION);
   localparam int CHW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

   ctrl_cmd_type   cmd;
   ctrl_sts_type   sts;
   logic           ram_we;
   logic [CHW-1:0] ram_waddr;
   logic [CHW-1:0] ram_raddr;
   logic [2*CW-1:0] ram_wdata;
   logic [2*CW-1:0] ram_rdata;

   mcpwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mcpwm_dp #(
      .CHANNELS   (CHANNELS),
      .RESOLUTION (RESOLUTION)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_channel    (req_channel),
      .req_on_count   (req_on_count),
      .req_off_count  (req_off_count),
      .req_pulse_us   (req_pulse_us),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_pin_levels (rsp_pin_levels),
      .rsp_status     (rsp_status),
      .rsp_read_on    (rsp_read_on),
      .rsp_read_off   (rsp_read_off)
   );

   mcpwm_ram #(
      .WIDTH (2 * CW),
      .DEPTH (CHANNELS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// ===== rtl/mcpwm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module mcpwm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mcpwm_ctrl.sv =====
// request sequencer: accepts requests, steps the datapath through each function
// and the high time recompute sweep; uses mcpwm_pkg
module mcpwm_ctrl
   import mcpwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CNT_WR,
      ST_DIV,
      ST_PLS_WR,
      ST_RD_WAIT,
      ST_DONE,
      ST_SW_RD,
      ST_SW_MUL,
      ST_SW_WR
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.sweep_pending) begin
               cmd.sweep_start = 1'b1;
               state_in        = ST_SW_RD;
            end else if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (sts.func == FUNC_TICK) begin
               cmd.do_tick = 1'b1;
               state_in    = ST_DONE;
            end else if (!sts.ch_valid) begin
               state_in = ST_DONE;
            end else begin
               unique case (sts.func)
                  FUNC_SET_COUNTS: state_in = ST_CNT_WR;
                  FUNC_SET_PULSE: begin
                     if (sts.pulse_full) begin
                        state_in = ST_PLS_WR;
                     end else begin
                        cmd.div_init = 1'b1;
                        state_in     = ST_DIV;
                     end
                  end
                  FUNC_READ: state_in = ST_RD_WAIT;
                  FUNC_DETACH: begin
                     cmd.do_detach = 1'b1;
                     state_in      = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CNT_WR: begin
            cmd.cnt_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_PLS_WR;
            end
         end
         ST_PLS_WR: begin
            cmd.pls_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SW_RD: begin
            cmd.addr_sweep = 1'b1;
            state_in       = ST_SW_MUL;
         end
         ST_SW_MUL: begin
            cmd.addr_sweep   = 1'b1;
            cmd.mul_from_ram = 1'b1;
            state_in         = ST_SW_WR;
         end
         ST_SW_WR: begin
            cmd.addr_sweep  = 1'b1;
            cmd.sweep_write = 1'b1;
            state_in        = sts.sweep_last ? ST_IDLE : ST_SW_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || sts.sweep_pending;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/mcpwm_dp.sv =====
// datapath: configuration registers, frame counter, channel high times,
// high time multiplier, pulse-to-count divider and response registers; uses mcpwm_pkg
module mcpwm_dp
   import mcpwm_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEFAULT,
   parameter int RESOLUTION = RESOLUTION_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [FUNC_W-1:0]                             req_func,
   input  logic [CHAN_W-1:0]                             req_channel,
   input  logic [COUNT_W-1:0]                            req_on_count,
   input  logic [COUNT_W-1:0]                            req_off_count,
   input  logic [PULSE_W-1:0]                            req_pulse_us,
   input  logic                                          csr_we,
   input  logic [CSR_INDEX_W-1:0]                        csr_index,
   input  logic [CSR_DATA_W-1:0]                         csr_wdata,
   input  ctrl_cmd_type                                  cmd,
   output ctrl_sts_type                                  sts,
   output logic                                          ram_we,
   output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ram_waddr,
   output logic [2*$clog2(RESOLUTION)-1:0]               ram_wdata,
   output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ram_raddr,
   input  logic [2*$clog2(RESOLUTION)-1:0]               ram_rdata,
   output logic [LEVELS_W-1:0]                           rsp_pin_levels,
   output logic                                          rsp_status,
   output logic [COUNT_W-1:0]                            rsp_read_on,
   output logic [COUNT_W-1:0]                            rsp_read_off
);

   localparam int CW     = $clog2(RESOLUTION);
   localparam int CHW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int DISP   = CHANNELS < LEVELS_W ? CHANNELS : LEVELS_W;
   localparam int DW     = DISP > 1 ? $clog2(DISP) : 1;
   localparam int DIVC_W = $clog2(CW + 1);
   localparam int PROD_W = PERIOD_W + CW;
   localparam logic [CHAN_W:0] CH_LIMIT   = (CHAN_W + 1)'(CHANNELS);
   localparam logic [CHAN_W:0] DISP_LIMIT = (CHAN_W + 1)'(DISP);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                sleep_ff, sleep_in;
   logic [PERIOD_W-1:0] fc_ff, fc_in;
   logic                pending_ff, pending_in;
   logic                active_ff [CHANNELS];
   logic                active_in [CHANNELS];
   logic [PERIOD_W-1:0] high_ff [DISP];
   logic [PERIOD_W-1:0] high_in [DISP];

   func_type            q_func_ff, q_func_in;
   logic [CHAN_W-1:0]   q_ch_ff, q_ch_in;
   logic [CW-1:0]       q_on_ff, q_on_in;
   logic [CW-1:0]       q_off_ff, q_off_in;
   logic [PULSE_W-1:0]  q_us_ff, q_us_in;

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]       quo_ff, quo_in;
   logic [DIVC_W-1:0]   divc_ff, divc_in;
   logic [DW-1:0]       idx_ff, idx_in;

   logic [COUNT_W-1:0]  rd_on_ff, rd_on_in;
   logic [COUNT_W-1:0]  rd_off_ff, rd_off_in;
   logic [LEVELS_W-1:0] levels_ff, levels_in;
   logic                status_ff, status_in;
   logic [COUNT_W-1:0]  out_on_ff, out_on_in;
   logic [COUNT_W-1:0]  out_off_ff, out_off_in;

   logic                ch_valid;
   logic                ch_disp;
   logic [CHW-1:0]      ch_idx;
   logic [DW-1:0]       hidx;
   logic [PERIOD_W-1:0] us_ext;
   logic                pulse_full;
   logic [PERIOD_W-1:0] us_clamp;
   logic [CW-1:0]       ram_on, ram_off;
   logic [15:0]         ram_on16, ram_off16;
   logic [15:0]         in_on16, in_off16;
   logic [CW-1:0]       mul_width;
   logic [PERIOD_W-1:0] high_new;
   logic [PERIOD_W:0]   div_shift;
   logic [PERIOD_W:0]   div_diff;
   logic                div_ge;
   logic [CW-1:0]       off_pulse;
   logic [PERIOD_W-1:0] fc_inc;
   logic [PERIOD_W-1:0] fc_wrap;
   logic [DISP-1:0]     lv;
   logic                status_now;
   logic [PERIOD_W-1:0] csr_period;

   assign ch_valid   = {1'b0, q_ch_ff} < CH_LIMIT;
   assign ch_disp    = {1'b0, q_ch_ff} < DISP_LIMIT;
   assign ch_idx     = q_ch_ff[CHW-1:0];
   assign hidx       = q_ch_ff[DW-1:0];
   assign us_ext     = PERIOD_W'(q_us_ff);
   assign pulse_full = us_ext >= period_ff;
   assign us_clamp   = pulse_full ? period_ff : us_ext;

   assign ram_on    = ram_rdata[2*CW-1:CW];
   assign ram_off   = ram_rdata[CW-1:0];
   assign ram_on16  = 16'(ram_on);
   assign ram_off16 = 16'(ram_off);
   assign in_on16   = 16'(req_on_count);
   assign in_off16  = 16'(req_off_count);

   // width in counts wraps modulo the resolution
   assign mul_width = cmd.mul_from_ram ? (ram_off - ram_on) : (q_off_ff - q_on_ff);
   assign prod_in   = PROD_W'(period_ff) * PROD_W'(mul_width);
   assign high_new  = prod_ff[CW +: PERIOD_W];

   assign div_shift = {rem_ff, 1'b0};
   assign div_ge    = div_shift >= {1'b0, period_ff};
   assign div_diff  = div_shift - {1'b0, period_ff};
   assign off_pulse = pulse_full ? CW'(RESOLUTION - 1) : quo_ff;

   assign fc_inc  = fc_ff + PERIOD_W'(1);
   assign fc_wrap = (fc_inc >= period_ff) ? '0 : fc_inc;

   assign csr_period = csr_wdata[PERIOD_W-1:0];

   assign status_now = !ch_valid && (q_func_ff == FUNC_SET_COUNTS ||
                       q_func_ff == FUNC_SET_PULSE || q_func_ff == FUNC_READ ||
                       q_func_ff == FUNC_DETACH);

   always_comb begin
      for (int i = 0; i < DISP; i++) begin
         lv[i] = !sleep_ff && (high_ff[i] != '0) &&
                 ((high_ff[i] >= period_ff) || (fc_ff < high_ff[i]));
      end
   end

   assign ram_we    = cmd.cnt_write || cmd.pls_write;
   assign ram_waddr = ch_idx;
   assign ram_wdata = cmd.cnt_write ? {q_on_ff, q_off_ff} : {{CW{1'b0}}, off_pulse};
   assign ram_raddr = cmd.addr_sweep ? CHW'(idx_ff) : ch_idx;

   always_comb begin
      period_in  = period_ff;
      sleep_in   = sleep_ff;
      fc_in      = fc_ff;
      pending_in = pending_ff;
      active_in  = active_ff;
      high_in    = high_ff;
      q_func_in  = q_func_ff;
      q_ch_in    = q_ch_ff;
      q_on_in    = q_on_ff;
      q_off_in   = q_off_ff;
      q_us_in    = q_us_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divc_in    = divc_ff;
      idx_in     = idx_ff;
      rd_on_in   = rd_on_ff;
      rd_off_in  = rd_off_ff;
      levels_in  = levels_ff;
      status_in  = status_ff;
      out_on_in  = out_on_ff;
      out_off_in = out_off_ff;

      if (cmd.req_load) begin
         q_func_in = func_type'(req_func);
         q_ch_in   = req_channel;
         q_on_in   = in_on16[CW-1:0];
         q_off_in  = in_off16[CW-1:0];
         q_us_in   = req_pulse_us;
         rd_on_in  = '0;
         rd_off_in = '0;
      end

      if (cmd.do_tick) begin
         fc_in = fc_wrap;
      end

      if (cmd.do_detach) begin
         active_in[ch_idx] = 1'b0;
         if (ch_disp) begin
            high_in[hidx] = '0;
         end
         if (active_ff[ch_idx]) begin
            fc_in = '0;
         end
      end

      if (cmd.cnt_write) begin
         active_in[ch_idx] = 1'b1;
         if (!sleep_ff) begin
            if (ch_disp) begin
               high_in[hidx] = high_new;
            end
            fc_in = '0;
         end
      end

      if (cmd.pls_write) begin
         active_in[ch_idx] = 1'b1;
         if (!sleep_ff) begin
            if (ch_disp) begin
               high_in[hidx] = us_clamp;
            end
            fc_in = '0;
         end
      end

      if (cmd.div_init) begin
         rem_in  = us_clamp;
         quo_in  = '0;
         divc_in = DIVC_W'(CW);
      end

      if (cmd.div_step) begin
         rem_in  = div_ge ? div_diff[PERIOD_W-1:0] : div_shift[PERIOD_W-1:0];
         quo_in  = {quo_ff[CW-2:0], div_ge};
         divc_in = divc_ff - DIVC_W'(1);
      end

      if (cmd.rd_capture) begin
         if (active_ff[ch_idx]) begin
            rd_on_in  = ram_on16[COUNT_W-1:0];
            rd_off_in = ram_off16[COUNT_W-1:0];
         end
      end

      if (cmd.sweep_start) begin
         idx_in     = '0;
         pending_in = 1'b0;
      end

      if (cmd.sweep_write) begin
         if (active_ff[CHW'(idx_ff)] && !sleep_ff) begin
            high_in[idx_ff] = high_new;
         end
         idx_in = idx_ff + DW'(1);
      end

      if (cmd.rsp_load) begin
         levels_in  = LEVELS_W'(lv);
         status_in  = status_now;
         out_on_in  = rd_on_ff;
         out_off_in = rd_off_ff;
      end

      if (csr_we) begin
         priority if (csr_index == CSR_PERIOD) begin
            period_in = (csr_period == '0) ? PERIOD_W'(1) : csr_period;
            fc_in     = '0;
            if (!sleep_ff) begin
               pending_in = 1'b1;
            end
         end else if (csr_index == CSR_SLEEP) begin
            if (csr_wdata[0] != sleep_ff) begin
               sleep_in = csr_wdata[0];
               fc_in    = '0;
               if (csr_wdata[0]) begin
                  high_in = '{default: '0};
               end else begin
                  pending_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         sleep_ff   <= 1'b0;
         fc_ff      <= '0;
         pending_ff <= 1'b0;
         active_ff  <= '{default: 1'b0};
         high_ff    <= '{default: '0};
      end else begin
         period_ff  <= period_in;
         sleep_ff   <= sleep_in;
         fc_ff      <= fc_in;
         pending_ff <= pending_in;
         active_ff  <= active_in;
         high_ff    <= high_in;
      end
      q_func_ff  <= q_func_in;
      q_ch_ff    <= q_ch_in;
      q_on_ff    <= q_on_in;
      q_off_ff   <= q_off_in;
      q_us_ff    <= q_us_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divc_ff    <= divc_in;
      idx_ff     <= idx_in;
      rd_on_ff   <= rd_on_in;
      rd_off_ff  <= rd_off_in;
      levels_ff  <= levels_in;
      status_ff  <= status_in;
      out_on_ff  <= out_on_in;
      out_off_ff <= out_off_in;
   end

   assign sts.func          = q_func_ff;
   assign sts.ch_valid      = ch_valid;
   assign sts.pulse_full    = pulse_full;
   assign sts.div_last      = divc_ff == DIVC_W'(1);
   assign sts.sweep_last    = idx_ff == DW'(DISP - 1);
   assign sts.sweep_pending = pending_ff;

   assign rsp_pin_levels = levels_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_on    = out_on_ff;
   assign rsp_read_off   = out_off_ff;

   logic [DISP-1:0] high_nz;
   logic [DISP-1:0] active_disp;

   always_comb begin
      for (int i = 0; i < DISP; i++) begin
         high_nz[i]     = high_ff[i] != '0;
         active_disp[i] = active_ff[i];
      end
   end

   a_frame_below_period: assert property (@(posedge clock) disable iff (reset)
      fc_ff < period_ff)
      else $error("frame counter reached the period");

   a_inactive_low: assert property (@(posedge clock) disable iff (reset)
      (high_nz & ~active_disp) == '0)
      else $error("inactive channel holds a high time");

   a_sleep_low: assert property (@(posedge clock) disable iff (reset)
      sleep_ff |-> high_nz == '0)
      else $error("high time kept while asleep");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < period_ff)
      else $error("divider remainder not below period");

endmodule
